@@ rtl/cti_pkg.sv @@
package cti_pkg;

    localparam int POS_WIDTH_DEFAULT       = 32;
    localparam int TIME_WIDTH_DEFAULT      = 16;
    localparam int SCALE_FRAC_BITS_DEFAULT = 16;

    localparam int DURATION_RESET = 100;

    localparam logic [1:0] FUNC_POSE  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    localparam logic [1:0] REG_TARGET_X = 2'd0;
    localparam logic [1:0] REG_TARGET_Y = 2'd1;
    localparam logic [1:0] REG_TARGET_Z = 2'd2;
    localparam logic [1:0] REG_DURATION = 2'd3;

    localparam logic [1:0] OP_T_SQUARE   = 2'd0;
    localparam logic [1:0] OP_NUMERATOR  = 2'd1;
    localparam logic [1:0] OP_DUR_SQUARE = 2'd2;
    localparam logic [1:0] OP_DUR_CUBE   = 2'd3;

endpackage

@@ rtl/cubic_trajectory_interpolator.sv @@
// Datapath: a non-final tick during motion computes its setpoint in the bit-serial shift-add
// multiplier, then the restoring divider, then the three bit-serial blend accumulators, and
// then waits in ST_EMIT until the output register is free. The final tick of a motion goes
// straight to ST_EMIT with the target; pose reports, starts and ignored beats stay in ST_IDLE.
// Throughput: one beat at a time; the next beat is taken once the setpoint enters the output
// register. Reset (aresetn low, synchronous) idles the block and clears targets and origin.
module cubic_trajectory_interpolator
    import cti_pkg::*;
#(
    parameter int POS_WIDTH       = POS_WIDTH_DEFAULT,
    parameter int TIME_WIDTH      = TIME_WIDTH_DEFAULT,
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEFAULT,
    localparam int DW             = (POS_WIDTH > 32) ? 64 : 32,
    localparam int AW             = (POS_WIDTH > 32) ? 5 : 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [AW-1:0]               paddr,
    input  logic [DW-1:0]               pwdata,
    output logic [DW-1:0]               prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_func,
    input  logic signed [POS_WIDTH-1:0] s_pos_x,
    input  logic signed [POS_WIDTH-1:0] s_pos_y,
    input  logic signed [POS_WIDTH-1:0] s_pos_z,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [POS_WIDTH-1:0] m_set_x,
    output logic signed [POS_WIDTH-1:0] m_set_y,
    output logic signed [POS_WIDTH-1:0] m_set_z,
    output logic                        m_last
);

    localparam int F     = SCALE_FRAC_BITS;
    localparam int MW    = 3 * TIME_WIDTH;
    localparam int ML    = TIME_WIDTH + 2;
    localparam int BW    = POS_WIDTH + SCALE_FRAC_BITS + 1;
    localparam int STEPS = (ML > F) ? ML : F;
    localparam int CW    = $clog2(STEPS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_BLEND = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic [1:0]                  op_reg, op_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic                        moving_reg, moving_next;
    logic [TIME_WIDTH-1:0]       elapsed_reg, elapsed_next;
    logic [TIME_WIDTH-1:0]       dur_reg, dur_next;
    logic signed [POS_WIDTH-1:0] target_reg [3];
    logic signed [POS_WIDTH-1:0] target_next [3];
    logic signed [POS_WIDTH-1:0] origin_reg [3];
    logic signed [POS_WIDTH-1:0] origin_next [3];
    logic signed [POS_WIDTH-1:0] pos_in [3];

    logic [MW-1:0]               acc_reg, acc_next;
    logic [MW-1:0]               mcand_reg, mcand_next;
    logic [ML-1:0]               mplier_reg, mplier_next;
    logic [MW-1:0]               num_reg, num_next;
    logic [MW-1:0]               den_reg, den_next;
    logic [MW-1:0]               rem_reg, rem_next;
    logic [F-1:0]                quo_reg, quo_next;
    logic [BW-1:0]               bacc_reg [3];
    logic [BW-1:0]               bacc_next [3];
    logic [BW-1:0]               bmcand_reg [3];
    logic [BW-1:0]               bmcand_next [3];
    logic [POS_WIDTH-1:0]        res_reg [3];
    logic [POS_WIDTH-1:0]        res_next [3];
    logic                        res_last_reg, res_last_next;

    logic                        m_valid_reg, m_valid_next;
    logic [POS_WIDTH-1:0]        set_reg [3];
    logic [POS_WIDTH-1:0]        set_next [3];
    logic                        last_reg, last_next;

    logic                        wr_en;
    logic                        out_free;
    logic [1:0]                  reg_index;
    logic [MW-1:0]               prod;
    logic [ML-1:0]               cubic_term;
    logic [MW:0]                 rem_shift;
    logic [BW-1:0]               bsum [3];

    assign pready    = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_set_x   = set_reg[0];
    assign m_set_y   = set_reg[1];
    assign m_set_z   = set_reg[2];
    assign m_last    = last_reg;
    assign pos_in[0] = s_pos_x;
    assign pos_in[1] = s_pos_y;
    assign pos_in[2] = s_pos_z;

    assign wr_en      = psel & penable & pwrite;
    assign reg_index  = paddr[AW-1:AW-2];
    assign out_free   = !m_valid_reg || m_ready;
    assign prod       = mplier_reg[0] ? (acc_reg + mcand_reg) : acc_reg;
    assign cubic_term = ML'(dur_reg) + {1'b0, dur_reg, 1'b0} - {1'b0, elapsed_reg, 1'b0};
    assign rem_shift  = {rem_reg, 1'b0};

    always_comb begin
        case (reg_index)
            REG_TARGET_X: prdata = DW'(target_reg[0]);
            REG_TARGET_Y: prdata = DW'(target_reg[1]);
            REG_TARGET_Z: prdata = DW'(target_reg[2]);
            REG_DURATION: prdata = DW'(dur_reg);
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            bsum[i] = quo_reg[0] ? (bacc_reg[i] + bmcand_reg[i]) : bacc_reg[i];
        end
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        cnt_next      = cnt_reg;
        moving_next   = moving_reg;
        elapsed_next  = elapsed_reg;
        dur_next      = dur_reg;
        acc_next      = acc_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        res_last_next = res_last_reg;
        m_valid_next  = m_valid_reg;
        last_next     = last_reg;
        for (int i = 0; i < 3; i++) begin
            target_next[i] = target_reg[i];
            origin_next[i] = origin_reg[i];
            bacc_next[i]   = bacc_reg[i];
            bmcand_next[i] = bmcand_reg[i];
            res_next[i]    = res_reg[i];
            set_next[i]    = set_reg[i];
        end

        if (wr_en) begin
            case (reg_index)
                REG_TARGET_X: target_next[0] = pwdata[POS_WIDTH-1:0];
                REG_TARGET_Y: target_next[1] = pwdata[POS_WIDTH-1:0];
                REG_TARGET_Z: target_next[2] = pwdata[POS_WIDTH-1:0];
                REG_DURATION: dur_next = pwdata[TIME_WIDTH-1:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_func)
                        FUNC_POSE: begin
                            if (!moving_reg) begin
                                for (int i = 0; i < 3; i++) begin
                                    origin_next[i] = pos_in[i];
                                end
                            end
                        end
                        FUNC_START: begin
                            if (!moving_reg) begin
                                moving_next  = 1'b1;
                                elapsed_next = '0;
                            end
                        end
                        FUNC_TICK: begin
                            if (moving_reg) begin
                                if (elapsed_reg >= dur_reg) begin
                                    for (int i = 0; i < 3; i++) begin
                                        res_next[i] = target_reg[i];
                                    end
                                    res_last_next = 1'b1;
                                    moving_next   = 1'b0;
                                    state_next    = ST_EMIT;
                                end else begin
                                    op_next     = OP_T_SQUARE;
                                    acc_next    = '0;
                                    mcand_next  = MW'(elapsed_reg);
                                    mplier_next = ML'(elapsed_reg);
                                    cnt_next    = '0;
                                    state_next  = ST_MUL;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                acc_next    = prod;
                mcand_next  = {mcand_reg[MW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[ML-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CW'(ML - 1)) begin
                    acc_next = '0;
                    cnt_next = '0;
                    case (op_reg)
                        OP_T_SQUARE: begin
                            op_next     = OP_NUMERATOR;
                            mcand_next  = prod;
                            mplier_next = cubic_term;
                        end
                        OP_NUMERATOR: begin
                            num_next    = prod;
                            op_next     = OP_DUR_SQUARE;
                            mcand_next  = MW'(dur_reg);
                            mplier_next = ML'(dur_reg);
                        end
                        OP_DUR_SQUARE: begin
                            op_next     = OP_DUR_CUBE;
                            mcand_next  = prod;
                            mplier_next = ML'(dur_reg);
                        end
                        OP_DUR_CUBE: begin
                            den_next   = prod;
                            rem_next   = num_reg;
                            quo_next   = '0;
                            state_next = ST_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                if (rem_shift >= {1'b0, den_reg}) begin
                    rem_next = MW'(rem_shift - {1'b0, den_reg});
                    quo_next = {quo_reg[F-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift[MW-1:0];
                    quo_next = {quo_reg[F-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(F - 1)) begin
                    cnt_next = '0;
                    for (int i = 0; i < 3; i++) begin
                        bacc_next[i]   = '0;
                        bmcand_next[i] = BW'(target_reg[i]) - BW'(origin_reg[i]);
                    end
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND: begin
                for (int i = 0; i < 3; i++) begin
                    bacc_next[i]   = bsum[i];
                    bmcand_next[i] = {bmcand_reg[i][BW-2:0], 1'b0};
                end
                quo_next = {1'b0, quo_reg[F-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(F - 1)) begin
                    cnt_next = '0;
                    for (int i = 0; i < 3; i++) begin
                        res_next[i] = origin_reg[i] + bsum[i][F +: POS_WIDTH];
                    end
                    res_last_next = 1'b0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        set_next[i] = res_reg[i];
                    end
                    last_next = res_last_reg;
                    if (!res_last_reg) begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_T_SQUARE;
            cnt_reg     <= '0;
            moving_reg  <= 1'b0;
            elapsed_reg <= '0;
            dur_reg     <= TIME_WIDTH'(DURATION_RESET);
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                target_reg[i] <= '0;
                origin_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            cnt_reg     <= cnt_next;
            moving_reg  <= moving_next;
            elapsed_reg <= elapsed_next;
            dur_reg     <= dur_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < 3; i++) begin
                target_reg[i] <= target_next[i];
                origin_reg[i] <= origin_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        res_last_reg <= res_last_next;
        last_reg     <= last_next;
        for (int i = 0; i < 3; i++) begin
            bacc_reg[i]   <= bacc_next[i];
            bmcand_reg[i] <= bmcand_next[i];
            res_reg[i]    <= res_next[i];
            set_reg[i]    <= set_next[i];
        end
    end

endmodule
